[src/cvs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for cell_voltage_stats.
// No dependencies; imported by the top level.
package cvs_pkg;

    localparam int unsigned NUM_CHAN = 6;
    localparam int unsigned MV_W     = 16;
    localparam int unsigned CHAN_W   = 3;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned FAULT_W  = 8;
    localparam int unsigned PSUM_W   = MV_W + 1;
    localparam int unsigned SUM_W    = MV_W + 3;
    localparam int unsigned RECIP_W  = 23;
    localparam int unsigned RECIP_SH = 22;
    localparam int unsigned PROD_W   = SUM_W + RECIP_W;
    localparam int unsigned IN_W     = NUM_CHAN * MV_W + FAULT_W;
    localparam int unsigned OUT_W    = 72;

    localparam logic [1:0] CFG_CELL_COUNT = 2'd0;
    localparam logic [1:0] CFG_MIN_MV     = 2'd1;
    localparam logic [1:0] CFG_MAX_MV     = 2'd2;

    localparam logic [CNT_W-1:0] RST_CELL_COUNT = 3'd6;
    localparam logic [MV_W-1:0]  RST_MIN_MV     = 16'd2000;
    localparam logic [MV_W-1:0]  RST_MAX_MV     = 16'd5000;

    localparam logic [RECIP_W-1:0] RECIP_ONE   = 23'd4194304;
    localparam logic [RECIP_W-1:0] RECIP_THIRD = 23'd1398102;
    localparam logic [RECIP_W-1:0] RECIP_FIFTH = 23'd838861;

    typedef struct packed {
        logic              vld;
        logic [MV_W-1:0]   mv;
        logic [CHAN_W-1:0] chan;
    } t_cand;

    typedef struct packed {
        logic [1:0]         shift;
        logic [RECIP_W-1:0] recip;
    } t_div;

    function automatic logic [NUM_CHAN-1:0] chan_mask(input logic [CNT_W-1:0] cells);
        logic [NUM_CHAN-1:0] mask;
        priority if (cells <= 3'd3) begin
            mask = 6'h13;
        end else if (cells == 3'd4) begin
            mask = 6'h17;
        end else if (cells == 3'd5) begin
            mask = 6'h1F;
        end else begin
            mask = 6'h3F;
        end
        return mask;
    endfunction

    // The lower-index candidate is a; b wins on a strict improvement or when a is not valid.
    function automatic t_cand merge_cand(input t_cand a, input t_cand b, input logic want_max);
        logic better;
        logic take_b;
        better = want_max ? (b.mv > a.mv) : (b.mv < a.mv);
        take_b = b.vld && (!a.vld || better);
        return take_b ? b : a;
    endfunction

    // Division by 1..6 as a pre-shift and a reciprocal multiply.
    function automatic t_div div_sel(input logic [CNT_W-1:0] cnt);
        t_div d;
        unique case (cnt)
            3'd1:    d = '{shift: 2'd0, recip: RECIP_ONE};
            3'd2:    d = '{shift: 2'd1, recip: RECIP_ONE};
            3'd3:    d = '{shift: 2'd0, recip: RECIP_THIRD};
            3'd4:    d = '{shift: 2'd2, recip: RECIP_ONE};
            3'd5:    d = '{shift: 2'd0, recip: RECIP_FIFTH};
            3'd6:    d = '{shift: 2'd1, recip: RECIP_THIRD};
            default: d = '{shift: 2'd0, recip: '0};
        endcase
        return d;
    endfunction

endpackage

[src/cell_voltage_stats.sv]
`timescale 1ns / 1ps
// Cell voltage statistics: windowed mean, minimum and maximum over six channels.
// Depends on cvs_pkg.
//
//  Channel   Dir  Payload (low bits first)
//  s_*       in   chan0_mv..chan5_mv (16 each), fault_flags (8)
//  m_*       out  avg_mv, high_mv, low_mv (16 each), high_chan, low_chan,
//                 used_count (3 each), fault_out (8), 7 zero pad bits
//  i_cfg_*   in   index 0 cell_count, 1 min_plausible_mv, 2 max_plausible_mv
//
// One snapshot is accepted per cycle unless an output stall backs up the pipeline.
// The filter stage takes a snapshot at the edge of its transaction, and the pair
// merge, final merge, reciprocal multiply and output register stages take it in turn.
// Each stage holds only when it is full and the stage after it holds, so bubbles are
// squeezed out during an output stall.
// Reset clears the valid bits and restores the register defaults.
module cell_voltage_stats (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [cvs_pkg::MV_W-1:0]    i_cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // chan0_mv, chan1_mv, chan2_mv, chan3_mv, chan4_mv, chan5_mv, fault_flags
    input  logic [cvs_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // avg_mv, high_mv, low_mv, high_chan, low_chan, used_count, fault_out, pad
    output logic [cvs_pkg::OUT_W-1:0]   m_tdata
);
    import cvs_pkg::*;

    logic [CNT_W-1:0] r_cell_count;
    logic [MV_W-1:0]  r_min_mv;
    logic [MV_W-1:0]  r_max_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= RST_CELL_COUNT;
            r_min_mv     <= RST_MIN_MV;
            r_max_mv     <= RST_MAX_MV;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CELL_COUNT: r_cell_count <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_MV:     r_min_mv     <= i_cfg_data;
                CFG_MAX_MV:     r_max_mv     <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic en1, en2, en3, en4, en_o;

    assign en_o = !r_vo || m_tready;
    assign en4  = !r_v4 || en_o;
    assign en3  = !r_v3 || en4;
    assign en2  = !r_v2 || en3;
    assign en1  = !r_v1 || en2;
    assign s_tready = en1;
    assign m_tvalid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1)  r_v1 <= s_tvalid;
            if (en2)  r_v2 <= r_v1;
            if (en3)  r_v3 <= r_v2;
            if (en4)  r_v4 <= r_v3;
            if (en_o) r_vo <= r_v4;
        end
    end

    // Stage 1: channel map and plausibility window.
    t_cand               n_c1 [NUM_CHAN];
    t_cand               r_c1 [NUM_CHAN];
    logic [FAULT_W-1:0]  r_fault1;
    logic [NUM_CHAN-1:0] mask;

    assign mask = chan_mask(r_cell_count);

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            n_c1[k].mv   = s_tdata[k*MV_W +: MV_W];
            n_c1[k].chan = CHAN_W'(k);
            n_c1[k].vld  = mask[k] && (n_c1[k].mv >= r_min_mv) && (n_c1[k].mv <= r_max_mv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_c1     <= n_c1;
            r_fault1 <= s_tdata[NUM_CHAN*MV_W +: FAULT_W];
        end
    end

    // Stage 2: pairwise merge, pair sums and used count.
    t_cand              r_lo2 [3];
    t_cand              r_hi2 [3];
    logic [PSUM_W-1:0]  r_ps2 [3];
    logic [CNT_W-1:0]   n_cnt2;
    logic [CNT_W-1:0]   r_cnt2;
    logic [FAULT_W-1:0] r_fault2;

    always_comb begin
        n_cnt2 = '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            n_cnt2 = n_cnt2 + CNT_W'(r_c1[k].vld);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int p = 0; p < 3; p++) begin
                r_lo2[p] <= merge_cand(r_c1[2*p], r_c1[2*p+1], 1'b0);
                r_hi2[p] <= merge_cand(r_c1[2*p], r_c1[2*p+1], 1'b1);
                r_ps2[p] <= (r_c1[2*p].vld ? PSUM_W'(r_c1[2*p].mv) : '0)
                          + (r_c1[2*p+1].vld ? PSUM_W'(r_c1[2*p+1].mv) : '0);
            end
            r_cnt2   <= n_cnt2;
            r_fault2 <= r_fault1;
        end
    end

    // Stage 3: final merge, total sum and divisor selection.
    t_cand              n_lo3, n_hi3;
    logic [MV_W-1:0]    r_lo3, r_hi3;
    logic [CHAN_W-1:0]  r_loc3, r_hic3;
    logic [SUM_W-1:0]   r_sum3;
    t_div               r_div3;
    logic [CNT_W-1:0]   r_cnt3;
    logic [FAULT_W-1:0] r_fault3;

    assign n_lo3 = merge_cand(merge_cand(r_lo2[0], r_lo2[1], 1'b0), r_lo2[2], 1'b0);
    assign n_hi3 = merge_cand(merge_cand(r_hi2[0], r_hi2[1], 1'b1), r_hi2[2], 1'b1);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_lo3    <= n_lo3.vld ? n_lo3.mv : '0;
            r_loc3   <= n_lo3.vld ? n_lo3.chan : '0;
            r_hi3    <= n_hi3.vld ? n_hi3.mv : '0;
            r_hic3   <= n_hi3.vld ? n_hi3.chan : '0;
            r_sum3   <= SUM_W'(r_ps2[0]) + SUM_W'(r_ps2[1]) + SUM_W'(r_ps2[2]);
            r_div3   <= div_sel(r_cnt2);
            r_cnt3   <= r_cnt2;
            r_fault3 <= r_fault2;
        end
    end

    // Stage 4: reciprocal multiply.
    logic [PROD_W-1:0]  r_prod4;
    logic [MV_W-1:0]    r_lo4, r_hi4;
    logic [CHAN_W-1:0]  r_loc4, r_hic4;
    logic [CNT_W-1:0]   r_cnt4;
    logic [FAULT_W-1:0] r_fault4;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_prod4  <= PROD_W'(r_sum3 >> r_div3.shift) * PROD_W'(r_div3.recip);
            r_lo4    <= r_lo3;
            r_hi4    <= r_hi3;
            r_loc4   <= r_loc3;
            r_hic4   <= r_hic3;
            r_cnt4   <= r_cnt3;
            r_fault4 <= r_fault3;
        end
    end

    // Output register.
    logic [OUT_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_out <= {7'd0, r_fault4, r_cnt4, r_loc4, r_hic4, r_lo4, r_hi4,
                      r_prod4[RECIP_SH +: MV_W]};
        end
    end

    assign m_tdata = r_out;

    a_none_used_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[56:54] == 3'd0) |-> (m_tdata[53:0] == '0))
        else $error("empty result carries nonzero statistics");

    a_high_ge_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[31:16] >= m_tdata[47:32]))
        else $error("high reading below low reading");

    a_avg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[15:0] <= m_tdata[31:16] && m_tdata[15:0] >= m_tdata[47:32]))
        else $error("mean outside the min/max span");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[56:54] <= 3'd6 && m_tdata[50:48] <= 3'd5
                      && m_tdata[53:51] <= 3'd5))
        else $error("count or channel index out of range");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for cell_voltage_stats: random and directed snapshots under
// several register settings, checked against a built-in predictor. Depends on cvs_pkg.
module testbench;
    import cvs_pkg::*;

    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;
    localparam int SETTLE_CYCLES = 10;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int RAND_PER_SETTING = 190;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [FAULT_W-1:0]             fault;
        logic [NUM_CHAN-1:0][MV_W-1:0]  mv;
    } cell_snapshot_t;

    typedef struct packed {
        logic [FAULT_W-1:0] fault_out;
        logic [CNT_W-1:0]   used_count;
        logic [CHAN_W-1:0]  low_chan;
        logic [CHAN_W-1:0]  high_chan;
        logic [MV_W-1:0]    low_mv;
        logic [MV_W-1:0]    high_mv;
        logic [MV_W-1:0]    avg_mv;
    } cell_stats_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_idx = '0;
    logic [MV_W-1:0]   i_cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    logic [CNT_W-1:0]  cfg_cells = RST_CELL_COUNT;
    logic [MV_W-1:0]   cfg_min = RST_MIN_MV;
    logic [MV_W-1:0]   cfg_max = RST_MAX_MV;

    cell_snapshot_t    pending_snapshots[$];
    cell_stats_t       expected_stats[$];
    cell_snapshot_t    bus_snapshot = '0;
    cell_stats_t       got_stats;
    cell_stats_t       want_stats;

    int tx_gap = 0;
    int rx_gap = 0;
    logic no_idle = 1'b0;
    int hold_req = 0;
    int hold_served = 0;
    int hold_left = 0;
    int failures = 0;
    int mismatches = 0;
    int snapshots_sent = 0;
    int results_checked = 0;
    int settings_used = 1;

    always #5 i_clk = ~i_clk;

    cell_voltage_stats uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    function automatic cell_stats_t compute_stats(input cell_snapshot_t snap);
        cell_stats_t      r;
        logic [5:0]       cells_in_use;
        logic [SUM_W-1:0] total;
        logic [CNT_W-1:0] n;
        logic [MV_W-1:0]  v;
        r = '0;
        total = '0;
        n = '0;
        if (cfg_cells <= 3'd3) begin
            cells_in_use = 6'b010011;
        end else if (cfg_cells == 3'd4) begin
            cells_in_use = 6'b010111;
        end else if (cfg_cells == 3'd5) begin
            cells_in_use = 6'b011111;
        end else begin
            cells_in_use = 6'b111111;
        end
        for (int k = 0; k < NUM_CHAN; k++) begin
            v = snap.mv[k];
            if (cells_in_use[k] && v >= cfg_min && v <= cfg_max) begin
                total = total + SUM_W'(v);
                if (n == 0 || v < r.low_mv) begin
                    r.low_mv = v;
                    r.low_chan = CHAN_W'(k);
                end
                if (n == 0 || v > r.high_mv) begin
                    r.high_mv = v;
                    r.high_chan = CHAN_W'(k);
                end
                n = n + 1'b1;
            end
        end
        if (n != 0) begin
            r.avg_mv = MV_W'(total / n);
        end
        r.used_count = n;
        r.fault_out = snap.fault;
        return r;
    endfunction

    function automatic logic [MV_W-1:0] rand_reading(input logic [MV_W-1:0] prior);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45 && cfg_min <= cfg_max) begin
            return MV_W'($urandom_range(cfg_max, cfg_min));
        end else if (pick < 53) begin
            return cfg_min;
        end else if (pick < 61) begin
            return cfg_max;
        end else if (pick < 66) begin
            return cfg_min - 1'b1;
        end else if (pick < 71) begin
            return cfg_max + 1'b1;
        end else if (pick < 84) begin
            return prior;
        end else if (pick < 89) begin
            return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        end
        return MV_W'($urandom);
    endfunction

    // Driver: one offered snapshot at a time, with random gaps between them.
    always @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            expected_stats.push_back(compute_stats(bus_snapshot));
            snapshots_sent++;
        end
        if (!s_tvalid || s_tready) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_snapshots.size() != 0) begin
                if (!no_idle && $urandom_range(0, 9) == 0) begin
                    tx_gap = $urandom_range(0, 5);
                    s_tvalid <= 1'b0;
                end else begin
                    bus_snapshot = pending_snapshots.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= bus_snapshot;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_served) begin
            hold_left <= RX_HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    // Monitor: checks each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            got_stats = m_tdata[$bits(cell_stats_t)-1:0];
            if (expected_stats.size() == 0) begin
                failures++;
                $display("unexpected result transaction: %h", m_tdata);
            end else begin
                want_stats = expected_stats.pop_front();
                results_checked++;
                if (got_stats !== want_stats) begin
                    failures++;
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("mismatch at result %0d (expected/actual):", results_checked);
                        $display("  avg %0d/%0d high %0d/%0d low %0d/%0d",
                                 want_stats.avg_mv, got_stats.avg_mv,
                                 want_stats.high_mv, got_stats.high_mv,
                                 want_stats.low_mv, got_stats.low_mv);
                        $display("  high_chan %0d/%0d low_chan %0d/%0d used %0d/%0d",
                                 want_stats.high_chan, got_stats.high_chan,
                                 want_stats.low_chan, got_stats.low_chan,
                                 want_stats.used_count, got_stats.used_count,
                                 " fault %h/%h", want_stats.fault_out, got_stats.fault_out);
                    end
                end
            end
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_register(input logic [1:0] idx, input logic [MV_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CELL_COUNT) begin
            cfg_cells = data[CNT_W-1:0];
        end else if (idx == CFG_MIN_MV) begin
            cfg_min = data;
        end else if (idx == CFG_MAX_MV) begin
            cfg_max = data;
        end
    endtask

    task automatic drain();
        while (pending_snapshots.size() != 0 || s_tvalid || expected_stats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [CNT_W-1:0] cells, input logic [MV_W-1:0] lo,
                                 input logic [MV_W-1:0] hi);
        logic [MV_W-1:0] cell_word;
        drain();
        cell_word = MV_W'($urandom);
        cell_word[CNT_W-1:0] = cells;
        write_register(CFG_CELL_COUNT, cell_word);
        write_register(CFG_MIN_MV, lo);
        write_register(CFG_MAX_MV, hi);
        settings_used++;
    endtask

    task automatic push_snapshot(input logic [MV_W-1:0] c0, input logic [MV_W-1:0] c1,
                                 input logic [MV_W-1:0] c2, input logic [MV_W-1:0] c3,
                                 input logic [MV_W-1:0] c4, input logic [MV_W-1:0] c5,
                                 input logic [FAULT_W-1:0] f);
        cell_snapshot_t snap;
        snap.mv = {c5, c4, c3, c2, c1, c0};
        snap.fault = f;
        pending_snapshots.push_back(snap);
    endtask

    task automatic queue_random(input int count);
        cell_snapshot_t snap;
        logic [MV_W-1:0] prior;
        for (int i = 0; i < count; i++) begin
            prior = MV_W'($urandom);
            for (int k = 0; k < NUM_CHAN; k++) begin
                snap.mv[k] = rand_reading(prior);
                prior = snap.mv[k];
            end
            snap.fault = FAULT_W'($urandom);
            pending_snapshots.push_back(snap);
        end
    endtask

    initial begin
        logic [MV_W-1:0] lo;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: six cells, window 2000 to 5000.
        push_snapshot(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00);
        push_snapshot(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        push_snapshot(16'd2000, 16'd2000, 16'd2000, 16'd2000, 16'd2000, 16'd2000, 8'h01);
        push_snapshot(16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd5000, 8'h80);
        push_snapshot(16'd1999, 16'd5001, 16'd1999, 16'd5001, 16'd1999, 16'd5001, 8'h3C);
        push_snapshot(16'd2000, 16'd5000, 16'd1999, 16'd5001, 16'd3000, 16'd3000, 8'hC3);
        push_snapshot(16'd2100, 16'd2200, 16'd2300, 16'd2400, 16'd2500, 16'd2600, 8'h11);
        push_snapshot(16'd4600, 16'd4500, 16'd4400, 16'd4300, 16'd4200, 16'd4100, 8'h22);
        push_snapshot(16'd3000, 16'd4000, 16'd4000, 16'd2500, 16'd2500, 16'd3000, 8'h44);
        push_snapshot(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4321, 8'h55);
        push_snapshot(16'd4999, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 8'hAA);
        push_snapshot(16'h0AAA, 16'h1555, 16'h0FFF, 16'h0800, 16'h1388, 16'h07D0, 8'h5A);
        push_snapshot(16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd2000, 8'hA5);
        queue_random(150);

        apply_setting(3'd3, 16'd2000, 16'd5000);
        push_snapshot(16'd2500, 16'd2600, 16'd4900, 16'd4950, 16'd2700, 16'd2100, 8'h0F);
        push_snapshot(16'd0, 16'd0, 16'd3000, 16'd3000, 16'd0, 16'd3000, 8'hF0);
        queue_random(RAND_PER_SETTING);
        hold_req <= hold_req + 1;

        apply_setting(3'd4, 16'd0, 16'hFFFF);
        push_snapshot(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h96);
        push_snapshot(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'h69);
        push_snapshot(16'd10, 16'd20, 16'd30, 16'hFFFF, 16'd40, 16'hFFFF, 8'h7E);
        queue_random(RAND_PER_SETTING);

        apply_setting(3'd5, 16'd3000, 16'd3600);
        queue_random(RAND_PER_SETTING);

        // Cell counts below three and above six.
        apply_setting(3'd0, 16'd1000, 16'd4200);
        queue_random(RAND_PER_SETTING);

        apply_setting(3'd7, 16'd2500, 16'd4500);
        write_register(CFG_SPARE_IDX, MV_W'($urandom));
        queue_random(RAND_PER_SETTING);
        hold_req <= hold_req + 1;

        // Inverted window, then a window of one value.
        apply_setting(3'd6, 16'd5000, 16'd2000);
        queue_random(130);
        apply_setting(3'd6, 16'd3300, 16'd3300);
        queue_random(130);

        lo = MV_W'($urandom_range(1500, 3500));
        apply_setting(CNT_W'($urandom_range(3, 6)), lo, lo + MV_W'($urandom_range(0, 2500)));
        queue_random(RAND_PER_SETTING);

        apply_setting(3'd6, 16'd0, 16'hFFFF);
        no_idle <= 1'b1;
        queue_random(160);

        drain();
        if (expected_stats.size() != 0) begin
            failures++;
        end
        $display("Sent %0d snapshots under %0d register settings; %0d results compared.",
                 snapshots_sent, settings_used, results_checked);
        $display("Failures: %0d (value mismatches: %0d).", failures, mismatches);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", expected_stats.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
src/cvs_pkg.sv
src/cell_voltage_stats.sv
dv/testbench.sv
